[src/fra_pkg.sv]
// Package for the fp32 rectifier activation unit: function codes and
// binary32 constants. No dependencies.
`timescale 1ns / 1ps
package fra_pkg;
  typedef enum logic [2:0] {
    FUNC_RELU  = 3'd0,
    FUNC_LEAKY = 3'd1,
    FUNC_CLIP  = 3'd2,
    FUNC_PRELU = 3'd3,
    FUNC_FLOOR = 3'd4
  } func_e;

  localparam logic [31:0] LeakyReset = 32'h3C23D70A;
  localparam logic [31:0] ClipReset  = 32'h40C00000;
  localparam logic [31:0] DefaultNan = 32'h7FC00000;
  localparam logic [31:0] ExpInf     = 32'h7F800000;
  localparam logic [31:0] QuietBit   = 32'h00400000;
  localparam logic [31:0] NegOne     = 32'hBF800000;

  localparam logic CfgLeaky = 1'b0;
  localparam logic CfgClip  = 1'b1;
endpackage

[src/fp32_rectifier_activation_unit.sv]
// Top level of the fp32 rectifier activation unit: five pipeline stages.
// start passes through the valid registers v1_q to v5_q; done_o is v5_q. Throughput: one request per cycle.
// busy is always low; the receiver cannot stall, so nothing ever waits.
// Reset clears the valid bits and loads the default slope and ceiling.
// Depends on fra_pkg.
`timescale 1ns / 1ps
module fp32_rectifier_activation_unit import fra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [31:0] x_value_i,
  input  logic [31:0] item_slope_i,
  input  logic        last_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] y_value_o,
  output logic        last_out_o
);
  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [31:0] leaky_q, clip_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaky_q <= LeakyReset;
      clip_q  <= ClipReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgLeaky) leaky_q <= cfg_data_i;
      else clip_q <= cfg_data_i;
    end
  end

  function automatic logic is_nan(input logic [31:0] a);
    return a[30:0] > ExpInf[30:0];
  endfunction

  function automatic logic [31:0] okey(input logic [31:0] a);
    return a[31] ? ~a : (a | 32'h80000000);
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // Stage 1: decode, side results, normalize the multiply operands.
  logic        v1_q, last1_q, mul1_q, spec1_q;
  logic [31:0] y1_q;
  logic        s1_q;
  logic [23:0] ma1_q, mb1_q;
  logic signed [9:0] ea1_q, eb1_q;

  logic [31:0] sl, fl, r, y1_d;
  logic        gt, mul_d, spec_d;
  logic [23:0] ma, mb;
  logic signed [9:0] ea, eb;
  logic [4:0]  la, lb, f;
  logic [31:0] fmask;

  always_comb begin
    sl = (func_i == FUNC_PRELU) ? item_slope_i : leaky_q;
    gt = !x_value_i[31] && x_value_i != 32'd0 && x_value_i <= ExpInf;
    // floor
    f = 5'd0;
    fmask = 32'd0;
    if (x_value_i[30:23] == 8'hFF)
      fl = is_nan(x_value_i) ? (x_value_i | QuietBit) : x_value_i;
    else if (x_value_i[30:23] >= 8'd150) fl = x_value_i;
    else if (x_value_i[30:23] < 8'd127)
      fl = (x_value_i[30:0] == 31'd0) ? x_value_i : (x_value_i[31] ? NegOne : 32'd0);
    else begin
      f = 5'(8'd150 - x_value_i[30:23]);
      fmask = (32'd1 << f) - 32'd1;
      if ((x_value_i & fmask) == 32'd0) fl = x_value_i;
      else fl = (x_value_i + (x_value_i[31] ? (32'd1 << f) : 32'd0)) & ~fmask;
    end
    r = gt ? x_value_i : 32'd0;
    mul_d = 1'b0;
    spec_d = 1'b0;
    case (func_i) inside
      FUNC_RELU: y1_d = r;
      FUNC_CLIP: begin
        if (is_nan(clip_q)) y1_d = clip_q;
        else if (r[30:0] == 31'd0 && clip_q[30:0] == 31'd0) y1_d = clip_q;
        else y1_d = (okey(r) < okey(clip_q)) ? r : clip_q;
      end
      FUNC_LEAKY, FUNC_PRELU: begin
        y1_d = x_value_i;
        if (!gt) begin
          if (is_nan(x_value_i)) y1_d = x_value_i | QuietBit;
          else if (is_nan(sl)) y1_d = sl | QuietBit;
          else if (x_value_i[30:23] == 8'hFF || sl[30:23] == 8'hFF) begin
            if (x_value_i[30:0] == 31'd0 || sl[30:0] == 31'd0) y1_d = DefaultNan;
            else y1_d = {x_value_i[31] ^ sl[31], ExpInf[30:0]};
          end else if (x_value_i[30:0] == 31'd0 || sl[30:0] == 31'd0)
            y1_d = {x_value_i[31] ^ sl[31], 31'd0};
          else mul_d = 1'b1;
        end
      end
      FUNC_FLOOR: y1_d = fl;
      default: y1_d = 32'd0;
    endcase
    spec_d = mul_d;
    ma = {x_value_i[30:23] != 8'd0, x_value_i[22:0]};
    mb = {sl[30:23] != 8'd0, sl[22:0]};
    la = lzc24(ma);
    lb = lzc24(mb);
    ea = (x_value_i[30:23] == 8'd0) ? (10'sd1 - $signed({5'd0, la}))
                                    : $signed({2'd0, x_value_i[30:23]});
    eb = (sl[30:23] == 8'd0) ? (10'sd1 - $signed({5'd0, lb}))
                             : $signed({2'd0, sl[30:23]});
    ma = ma << la;
    mb = mb << lb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    last1_q <= last_in_i;
    y1_q    <= y1_d;
    mul1_q  <= mul_d;
    spec1_q <= spec_d;
    s1_q    <= x_value_i[31] ^ sl[31];
    ma1_q   <= ma;
    mb1_q   <= mb;
    ea1_q   <= ea;
    eb1_q   <= eb;
  end

  // Stage 2: 24x24 mantissa product.
  logic        v2_q, last2_q, mul2_q, s2_q;
  logic [31:0] y2_q;
  logic [47:0] p2_q;
  logic signed [9:0] e2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    last2_q <= last1_q;
    y2_q    <= y1_q;
    mul2_q  <= mul1_q & spec1_q;
    s2_q    <= s1_q;
    p2_q    <= {24'd0, ma1_q} * {24'd0, mb1_q};
    e2_q    <= ea1_q + eb1_q - 10'sd126;
  end

  // Stage 3: normalize by one and shift right for underflow with sticky.
  logic        v3_q, last3_q, mul3_q, s3_q;
  logic [31:0] y3_q;
  logic [47:0] p3_q;
  logic signed [9:0] e3_q;
  logic [47:0] pn, smask;
  logic signed [9:0] en, sh;
  always_comb begin
    pn = p2_q;
    en = e2_q;
    if (!p2_q[47]) begin
      pn = p2_q << 1;
      en = e2_q - 10'sd1;
    end
    smask = 48'd0;
    sh = 10'sd1 - en;
    if (en <= 10'sd0) begin
      if (sh >= 10'sd48) pn = {47'd0, pn != 48'd0};
      else begin
        smask = (48'd1 << sh[5:0]) - 48'd1;
        pn = (pn >> sh[5:0]) | {47'd0, (pn & smask) != 48'd0};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    last3_q <= last2_q;
    y3_q    <= y2_q;
    mul3_q  <= mul2_q;
    s3_q    <= s2_q;
    p3_q    <= pn;
    e3_q    <= en;
  end

  // Stage 4: round to nearest even and pack.
  logic        v4_q, last4_q;
  logic [31:0] y4_q;
  logic [24:0] m;
  logic [32:0] pack;
  logic [31:0] prod;
  always_comb begin
    m = {1'b0, p3_q[47:24]};
    if (p3_q[23:0] > 24'h800000 || (p3_q[23:0] == 24'h800000 && m[0])) m = m + 25'd1;
    pack = (e3_q > 10'sd0) ? {2'd0, 8'(e3_q - 10'sd1), 23'd0} : 33'd0;
    pack = pack + {8'd0, m};
    if ((e3_q >= 10'sd256) || pack >= {1'b0, ExpInf}) prod = {s3_q, ExpInf[30:0]};
    else prod = {s3_q, pack[30:0]};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    last4_q <= last3_q;
    y4_q    <= mul3_q ? prod : y3_q;
  end

  // Stage 5: output register.
  logic        v5_q, last5_q;
  logic [31:0] y5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    last5_q <= last4_q;
    y5_q    <= y4_q;
  end

  assign done_o     = v5_q;
  assign y_value_o  = y5_q;
  assign last_out_o = last5_q;
endmodule
